// File: rtl/lfps_pkg.sv
// ----------------------------------------------------------------------------
// Line follower steering package
// Shared constants, payload words, register indexes, mode and state codes
// for the line follower PID steering core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfps_pkg;

   // Sensor array and datapath sizing.
   localparam int NUM_SENSORS   = 6;
   localparam int SAMPLE_BITS   = 10;
   localparam int INTEGRAL_BITS = 24;

   // Register and field widths fixed by the interface.
   localparam int SPEED_W  = 8;
   localparam int POS_W    = 4;
   localparam int THRESH_W = 10;
   localparam int GAIN_W   = 10;
   localparam int ERR_W    = POS_W + 1;
   localparam int DERR_W   = ERR_W + 1;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   // Derived widths for position arithmetic.
   localparam int SUM_MAX = 2 * (NUM_SENSORS - 1) * NUM_SENSORS;
   localparam int SUM_W   = $clog2(SUM_MAX + 1);
   localparam int CNT_W   = $clog2(NUM_SENSORS + 1);
   localparam int CMP_W   = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;
   localparam int QX_W    = (SUM_W > POS_W) ? SUM_W : POS_W;

   // Multiply-accumulate widths: signed gain times signed operand.
   localparam int OPA_W  = GAIN_W + 1;
   localparam int PROD_W = OPA_W + INTEGRAL_BITS;
   localparam int ACC_W  = PROD_W + 2;
   localparam int DUTY_W = ACC_W + 1;

   // Register reset values.
   localparam logic [SPEED_W-1:0]  BASE_SPEED_RST = SPEED_W'(80);
   localparam logic [SPEED_W-1:0]  MAX_SPEED_RST  = SPEED_W'(100);
   localparam logic [POS_W-1:0]    SET_POINT_RST  = POS_W'(5);
   localparam logic [THRESH_W-1:0] THRESHOLD_RST  = THRESH_W'(600);
   localparam logic [GAIN_W-1:0]   GAIN_P_RST     = GAIN_W'(300);
   localparam logic [GAIN_W-1:0]   GAIN_D_RST     = GAIN_W'(350);
   localparam logic [GAIN_W-1:0]   GAIN_I_RST     = GAIN_W'(0);

   // Largest position that the output can carry.
   localparam logic [QX_W-1:0] POS_SAT = QX_W'(15);

   // Edge patterns that start a spin, and the centered pattern that ends it.
   localparam logic [NUM_SENSORS-1:0] RIGHT_PAT_0 = NUM_SENSORS'(6'b011111);
   localparam logic [NUM_SENSORS-1:0] RIGHT_PAT_1 = NUM_SENSORS'(6'b001111);
   localparam logic [NUM_SENSORS-1:0] RIGHT_PAT_2 = NUM_SENSORS'(6'b000111);
   localparam logic [NUM_SENSORS-1:0] LEFT_PAT_0  = NUM_SENSORS'(6'b111110);
   localparam logic [NUM_SENSORS-1:0] LEFT_PAT_1  = NUM_SENSORS'(6'b111100);
   localparam logic [NUM_SENSORS-1:0] LEFT_PAT_2  = NUM_SENSORS'(6'b111000);
   localparam logic [NUM_SENSORS-1:0] CENTER_PAT  = NUM_SENSORS'(6'b001100);

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_SPEED = 3'd0,
      CSR_MAX_SPEED  = 3'd1,
      CSR_SET_POINT  = 3'd2,
      CSR_THRESHOLD  = 3'd3,
      CSR_GAIN_P     = 3'd4,
      CSR_GAIN_D     = 3'd5,
      CSR_GAIN_I     = 3'd6
   } csr_index_type;

   // Drive modes.
   typedef enum logic [1:0] {
      MODE_FOLLOW = 2'd0,
      MODE_RIGHT  = 2'd1,
      MODE_LEFT   = 2'd2
   } mode_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_POS,
      ST_PID,
      ST_MUL_P,
      ST_MUL_D,
      ST_MUL_I,
      ST_ACC_I,
      ST_LEFT,
      ST_RIGHT,
      ST_DONE
   } state_type;

   // Control of the shared multiply-accumulate unit.
   typedef struct packed {
      logic clear;
      logic mul_en;
      logic acc_en;
   } mac_ctl_type;

   // One scan of sensor samples.
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample_0;
      logic [SAMPLE_BITS-1:0] sample_1;
      logic [SAMPLE_BITS-1:0] sample_2;
      logic [SAMPLE_BITS-1:0] sample_3;
      logic [SAMPLE_BITS-1:0] sample_4;
      logic [SAMPLE_BITS-1:0] sample_5;
   } req_word_type;

   // One steering result.
   typedef struct packed {
      logic [SPEED_W-1:0]     left_speed;
      logic [SPEED_W-1:0]     right_speed;
      logic                   left_reverse;
      logic                   right_reverse;
      mode_type               drive_mode;
      logic [NUM_SENSORS-1:0] line_pattern;
      logic [POS_W-1:0]       line_position;
   } rsp_word_type;

endpackage

// File: rtl/lfps_div.sv
// ----------------------------------------------------------------------------
// Line follower position divider
// Restoring divider that takes one quotient bit per cycle; it divides the
// weighted sum of the set sensor bits by their count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfps_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [lfps_pkg::SUM_W-1:0] dividend,
   input  logic [lfps_pkg::CNT_W-1:0] divisor,
   output logic                      busy,
   output logic [lfps_pkg::SUM_W-1:0] quotient
);
   import lfps_pkg::*;

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SUM_W-1:0]  quot_ff, quot_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  dvsr_ff, dvsr_in;
   logic [CNT_W:0]    rem_sh;
   logic [CNT_W:0]    rem_diff;

   // One restoring step: shift in the next dividend bit and try a subtract.
   always_comb begin
      rem_sh   = {rem_ff, quot_ff[SUM_W-1]};
      rem_diff = rem_sh - {1'b0, dvsr_ff};
      busy_in  = busy_ff;
      step_in  = step_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      dvsr_in  = dvsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(SUM_W);
         quot_in = dividend;
         rem_in  = '0;
         dvsr_in = divisor;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dvsr_ff}) begin
            rem_in  = rem_diff[CNT_W-1:0];
            quot_in = {quot_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[CNT_W-1:0];
            quot_in = {quot_ff[SUM_W-2:0], 1'b0};
         end
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvsr_ff <= dvsr_in;
   end

   assign busy     = busy_ff;
   assign quotient = quot_ff;

endmodule

// File: rtl/lfps_mac.sv
// ----------------------------------------------------------------------------
// Line follower multiply-accumulate unit
// Shared signed multiplier with a registered product and an accumulator;
// the three PID terms pass through it one after another.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfps_mac (
   input  logic                              clock,
   input  lfps_pkg::mac_ctl_type             ctl,
   input  logic signed [lfps_pkg::OPA_W-1:0]  op_a,
   input  logic signed [lfps_pkg::INTEGRAL_BITS-1:0] op_b,
   output logic signed [lfps_pkg::ACC_W-1:0]  acc
);
   import lfps_pkg::*;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;

   // Product of this cycle; the sum of the previous product.
   always_comb begin
      prod_in = ctl.mul_en ? (op_a * op_b) : prod_ff;
      acc_in  = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (ctl.acc_en) begin
         acc_in = acc_ff + {{(ACC_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// File: rtl/line_follow_pid_steering_core.sv
// ----------------------------------------------------------------------------
// Line follower PID steering core
// Each accepted scan passes the six divider steps and then, in follow mode,
// the PID sequence, which is skipped while spinning. Only one scan is in
// flight at a time: the next word is taken once the previous result sits in
// the output register. Synchronous reset restores the register defaults,
// follow mode and a cleared PID history.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_follow_pid_steering_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  lfps_pkg::req_word_type             req_word,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output lfps_pkg::rsp_word_type             rsp_word,
   input  logic                               csr_wr_en,
   input  logic [lfps_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lfps_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import lfps_pkg::*;

   // Configuration registers.
   logic [SPEED_W-1:0]  base_speed_ff;
   logic [SPEED_W-1:0]  max_speed_ff;
   logic [POS_W-1:0]    set_point_ff;
   logic [THRESH_W-1:0] threshold_ff;
   logic [GAIN_W-1:0]   gain_p_ff;
   logic [GAIN_W-1:0]   gain_d_ff;
   logic [GAIN_W-1:0]   gain_i_ff;

   // Sequencer and controller state.
   state_type                        state_ff, state_in;
   mode_type                         mode_ff, mode_in;
   logic signed [ERR_W-1:0]          prev_err_ff, prev_err_in;
   logic signed [INTEGRAL_BITS-1:0]  integral_ff, integral_in;
   logic [POS_W-1:0]                 held_pos_ff, held_pos_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   // Working registers of the current scan.
   logic [NUM_SENSORS-1:0]           pattern_ff, pattern_in;
   logic [CNT_W-1:0]                 count_ff, count_in;
   logic [POS_W-1:0]                 pos_ff, pos_in;
   logic signed [ERR_W-1:0]          err_ff, err_in;
   logic signed [DERR_W-1:0]         derr_ff, derr_in;
   logic [SPEED_W-1:0]               lspd_ff, lspd_in;
   logic [SPEED_W-1:0]               rspd_ff, rspd_in;
   logic                             lrev_ff, lrev_in;
   logic                             rrev_ff, rrev_in;
   rsp_word_type                     rsp_word_ff, rsp_word_in;

   // Scan decode.
   logic [SAMPLE_BITS-1:0] samples [NUM_SENSORS];
   logic [NUM_SENSORS-1:0] scan_pattern;
   logic [SUM_W-1:0]       scan_sum;
   logic [CNT_W-1:0]       scan_count;
   logic                   req_accept;

   // Shared units.
   logic                             div_start;
   logic                             div_busy;
   logic [SUM_W-1:0]                 div_quot;
   mac_ctl_type                      mac_ctl;
   logic signed [OPA_W-1:0]          mac_a;
   logic signed [INTEGRAL_BITS-1:0]  mac_b;
   logic signed [ACC_W-1:0]          mac_acc;

   // Combinational helpers.
   logic [QX_W-1:0]                  quot_x;
   logic [POS_W-1:0]                 scan_pos;
   mode_type                         next_mode;
   logic signed [ERR_W-1:0]          pid_err;
   logic signed [INTEGRAL_BITS:0]    int_sum;
   logic signed [DUTY_W-1:0]         duty;
   logic signed [DUTY_W-1:0]         base_x;
   logic signed [DUTY_W-1:0]         acc_x;
   logic [SPEED_W-1:0]               duty_clamp;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);

   // Compare every sample against the threshold and weigh the set bits.
   always_comb begin
      samples[0] = req_word.sample_0;
      samples[1] = req_word.sample_1;
      samples[2] = req_word.sample_2;
      samples[3] = req_word.sample_3;
      samples[4] = req_word.sample_4;
      samples[5] = req_word.sample_5;
      scan_sum   = '0;
      scan_count = '0;
      for (int i = 0; i < NUM_SENSORS; i++) begin
         scan_pattern[i] = (CMP_W'(samples[i]) <= CMP_W'(threshold_ff));
         if (scan_pattern[i]) begin
            scan_sum   = scan_sum + SUM_W'(2 * i);
            scan_count = scan_count + CNT_W'(1);
         end
      end
   end

   assign div_start = req_accept;

   lfps_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (scan_sum),
      .divisor  (scan_count),
      .busy     (div_busy),
      .quotient (div_quot)
   );

   lfps_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .acc   (mac_acc)
   );

   // Position of this scan, held when no sensor sees the line.
   always_comb begin
      quot_x = QX_W'(div_quot);
      if (count_ff == '0) begin
         scan_pos = held_pos_ff;
      end else if (quot_x > POS_SAT) begin
         scan_pos = POS_SAT[POS_W-1:0];
      end else begin
         scan_pos = quot_x[POS_W-1:0];
      end
   end

   // Mode change for this scan's pattern.
   always_comb begin
      next_mode = mode_ff;
      if (mode_ff == MODE_FOLLOW) begin
         if (pattern_ff inside {RIGHT_PAT_0, RIGHT_PAT_1, RIGHT_PAT_2}) begin
            next_mode = MODE_RIGHT;
         end else if (pattern_ff inside {LEFT_PAT_0, LEFT_PAT_1, LEFT_PAT_2}) begin
            next_mode = MODE_LEFT;
         end
      end else if (pattern_ff == CENTER_PAT) begin
         next_mode = MODE_FOLLOW;
      end
   end

   // Error and saturating integral.
   always_comb begin
      pid_err = $signed({1'b0, pos_ff}) - $signed({1'b0, set_point_ff});
      int_sum = {integral_ff[INTEGRAL_BITS-1], integral_ff}
              + {{(INTEGRAL_BITS + 1 - ERR_W){pid_err[ERR_W-1]}}, pid_err};
   end

   // Duty for one motor: base plus or minus the correction, clamped.
   always_comb begin
      base_x = $signed({{(DUTY_W - SPEED_W){1'b0}}, base_speed_ff});
      acc_x  = {mac_acc[ACC_W-1], mac_acc};
      duty   = (state_ff == ST_LEFT) ? (base_x + acc_x) : (base_x - acc_x);
      if (duty[DUTY_W-1]) begin
         duty_clamp = '0;
      end else if (duty > $signed({{(DUTY_W - SPEED_W){1'b0}}, max_speed_ff})) begin
         duty_clamp = max_speed_ff;
      end else begin
         duty_clamp = duty[SPEED_W-1:0];
      end
   end

   // Sequencer: next state, working registers and unit controls.
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      prev_err_in  = prev_err_ff;
      integral_in  = integral_ff;
      held_pos_in  = held_pos_ff;
      rsp_valid_in = rsp_valid_ff;
      pattern_in   = pattern_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      err_in       = err_ff;
      derr_in      = derr_ff;
      lspd_in      = lspd_ff;
      rspd_in      = rspd_ff;
      lrev_in      = lrev_ff;
      rrev_in      = rrev_ff;
      rsp_word_in  = rsp_word_ff;
      mac_ctl      = '0;
      mac_a        = '0;
      mac_b        = '0;

      // The output word leaves when the consumer takes it.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               pattern_in = scan_pattern;
               count_in   = scan_count;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!div_busy) begin
               state_in = ST_POS;
            end
         end
         ST_POS: begin
            pos_in      = scan_pos;
            held_pos_in = scan_pos;
            mode_in     = next_mode;
            lspd_in     = max_speed_ff;
            rspd_in     = max_speed_ff;
            lrev_in     = (next_mode == MODE_LEFT);
            rrev_in     = (next_mode == MODE_RIGHT);
            state_in    = (next_mode == MODE_FOLLOW) ? ST_PID : ST_DONE;
         end
         ST_PID: begin
            err_in      = pid_err;
            derr_in     = {pid_err[ERR_W-1], pid_err} - {prev_err_ff[ERR_W-1], prev_err_ff};
            prev_err_in = pid_err;
            if (int_sum[INTEGRAL_BITS] != int_sum[INTEGRAL_BITS-1]) begin
               integral_in = int_sum[INTEGRAL_BITS]
                  ? {1'b1, {(INTEGRAL_BITS - 1){1'b0}}}
                  : {1'b0, {(INTEGRAL_BITS - 1){1'b1}}};
            end else begin
               integral_in = int_sum[INTEGRAL_BITS-1:0];
            end
            lrev_in     = 1'b0;
            rrev_in     = 1'b0;
            mac_ctl.clear = 1'b1;
            state_in    = ST_MUL_P;
         end
         ST_MUL_P: begin
            mac_ctl.mul_en = 1'b1;
            mac_a    = $signed({1'b0, gain_p_ff});
            mac_b    = {{(INTEGRAL_BITS - ERR_W){err_ff[ERR_W-1]}}, err_ff};
            state_in = ST_MUL_D;
         end
         ST_MUL_D: begin
            mac_ctl.mul_en = 1'b1;
            mac_ctl.acc_en = 1'b1;
            mac_a    = $signed({1'b0, gain_d_ff});
            mac_b    = {{(INTEGRAL_BITS - DERR_W){derr_ff[DERR_W-1]}}, derr_ff};
            state_in = ST_MUL_I;
         end
         ST_MUL_I: begin
            mac_ctl.mul_en = 1'b1;
            mac_ctl.acc_en = 1'b1;
            mac_a    = $signed({1'b0, gain_i_ff});
            mac_b    = integral_ff;
            state_in = ST_ACC_I;
         end
         ST_ACC_I: begin
            mac_ctl.acc_en = 1'b1;
            state_in = ST_LEFT;
         end
         ST_LEFT: begin
            lspd_in  = duty_clamp;
            state_in = ST_RIGHT;
         end
         ST_RIGHT: begin
            rspd_in  = duty_clamp;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Load the output word once the previous one has gone.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_word_in.left_speed    = lspd_ff;
               rsp_word_in.right_speed   = rspd_ff;
               rsp_word_in.left_reverse  = lrev_ff;
               rsp_word_in.right_reverse = rrev_ff;
               rsp_word_in.drive_mode    = mode_ff;
               rsp_word_in.line_pattern  = pattern_ff;
               rsp_word_in.line_position = pos_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mode_ff       <= MODE_FOLLOW;
         prev_err_ff   <= '0;
         integral_ff   <= '0;
         held_pos_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         base_speed_ff <= BASE_SPEED_RST;
         max_speed_ff  <= MAX_SPEED_RST;
         set_point_ff  <= SET_POINT_RST;
         threshold_ff  <= THRESHOLD_RST;
         gain_p_ff     <= GAIN_P_RST;
         gain_d_ff     <= GAIN_D_RST;
         gain_i_ff     <= GAIN_I_RST;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         prev_err_ff  <= prev_err_in;
         integral_ff  <= integral_in;
         held_pos_ff  <= held_pos_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_BASE_SPEED: base_speed_ff <= csr_wdata[SPEED_W-1:0];
               CSR_MAX_SPEED:  max_speed_ff  <= csr_wdata[SPEED_W-1:0];
               CSR_SET_POINT:  set_point_ff  <= csr_wdata[POS_W-1:0];
               CSR_THRESHOLD:  threshold_ff  <= csr_wdata[THRESH_W-1:0];
               CSR_GAIN_P:     gain_p_ff     <= csr_wdata[GAIN_W-1:0];
               CSR_GAIN_D:     gain_d_ff     <= csr_wdata[GAIN_W-1:0];
               CSR_GAIN_I:     gain_i_ff     <= csr_wdata[GAIN_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Working registers of the current scan and the output word.
   always_ff @(posedge clock) begin
      pattern_ff  <= pattern_in;
      count_ff    <= count_in;
      pos_ff      <= pos_in;
      err_ff      <= err_in;
      derr_ff     <= derr_in;
      lspd_ff     <= lspd_in;
      rspd_ff     <= rspd_in;
      lrev_ff     <= lrev_in;
      rrev_ff     <= rrev_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
